@@ design/integer_stack_machine_execute_unit_defines.svh @@
// assertion macros shared by the stack machine execute unit
// no dependencies; included by files that carry concurrent assertions
`ifndef INTEGER_STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define INTEGER_STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ISM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ISM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/ism_pkg.sv @@
// types, codes and sizes for the integer stack machine execute unit
// no dependencies; used by every module of the block
package ism_pkg;

  // sizes
  localparam int STACK_DEPTH  = 16;
  localparam int PROGRAM_SIZE = 256;
  localparam int SP_W         = $clog2(STACK_DEPTH);
  localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
  localparam int PC_W         = 9;
  localparam int DATA_W       = 32;
  localparam int ACT_W        = 4;
  localparam int STAT_W       = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // raw action codes on the input channel
  localparam logic [ACT_W-1:0] ACT_PUSH = 4'd0;
  localparam logic [ACT_W-1:0] ACT_ADD  = 4'd1;
  localparam logic [ACT_W-1:0] ACT_SUB  = 4'd2;
  localparam logic [ACT_W-1:0] ACT_MUL  = 4'd3;
  localparam logic [ACT_W-1:0] ACT_DIV  = 4'd4;
  localparam logic [ACT_W-1:0] ACT_RET  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_BZ   = 4'd6;
  localparam logic [ACT_W-1:0] ACT_JMP  = 4'd7;

  // decoded operation class
  typedef enum logic [3:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_RET,
    OP_BZ,
    OP_JMP,
    OP_NOP
  } op_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_RUNNING   = 3'd0,
    ST_RETURNED  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_ENDED     = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_HALTED    = 3'd6
  } status_t;

  // decoded instruction handed from front to back
  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] imm;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    status_t           status;
    logic [DATA_W-1:0] return_value;
  } result_t;

  // action code to operation class; unknown codes act as no-op
  function automatic op_t decode_action(input logic [ACT_W-1:0] act);
    op_t op;
    case (act)
      ACT_PUSH: op = OP_PUSH;
      ACT_ADD:  op = OP_ADD;
      ACT_SUB:  op = OP_SUB;
      ACT_MUL:  op = OP_MUL;
      ACT_DIV:  op = OP_DIV;
      ACT_RET:  op = OP_RET;
      ACT_BZ:   op = OP_BZ;
      ACT_JMP:  op = OP_JMP;
      default:  op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

@@ design/ism_front.sv @@
// front end: accepts instruction transactions, decodes them, queues them
// depends on ism_pkg
module ism_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ism_pkg::ACT_W-1:0]   in_action,
  input  logic [ism_pkg::DATA_W-1:0]  in_imm,
  output logic                        item_valid,
  output ism_pkg::item_t              item,
  input  logic                        item_pop
);

  ism_pkg::item_t                   queue [ism_pkg::QUEUE_DEPTH];
  logic [ism_pkg::QPTR_W-1:0]       wr_ptr;
  logic [ism_pkg::QPTR_W-1:0]       rd_ptr;
  logic [ism_pkg::QCNT_W-1:0]       fill;
  logic                             push;
  logic                             pop;

  assign in_ready   = fill < ism_pkg::QCNT_W'(ism_pkg::QUEUE_DEPTH);
  assign item_valid = fill != '0;
  assign item       = queue[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = item_pop && item_valid;

  // queue storage, decoded on the way in
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{op: ism_pkg::decode_action(in_action), imm: in_imm};
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ design/ism_div.sv @@
// iterative unsigned 32-bit divider, one quotient bit per cycle
// depends on ism_pkg
module ism_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ism_pkg::DATA_W-1:0]  dividend,
  input  logic [ism_pkg::DATA_W-1:0]  divisor,
  output logic                        done,
  output logic [ism_pkg::DATA_W-1:0]  quotient
);

  localparam int STEP_W = $clog2(ism_pkg::DATA_W);

  logic [ism_pkg::DATA_W:0]    rem;
  logic [ism_pkg::DATA_W-1:0]  dvs;
  logic [STEP_W-1:0]           step;
  logic                        busy;
  logic [ism_pkg::DATA_W:0]    rem_sh;
  logic                        ge;

  // shift in the next dividend bit and trial subtract
  assign rem_sh = {rem[ism_pkg::DATA_W-1:0], quotient[ism_pkg::DATA_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? rem_sh - {1'b0, dvs} : rem_sh;
      quotient <= {quotient[ism_pkg::DATA_W-2:0], ge};
    end
  end

  // step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '1;
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/ism_exec.sv @@
// back end: runs decoded instructions against the operand stack and pc
// depends on ism_pkg, ism_div and the assertion macro header
`include "integer_stack_machine_execute_unit_defines.svh"

module ism_exec (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [ism_pkg::PC_W-1:0]    cfg_wdata,
  input  logic                        item_valid,
  input  ism_pkg::item_t              item,
  output logic                        item_pop,
  output logic                        res_valid,
  output ism_pkg::result_t            res,
  input  logic                        res_ready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_WB   = 4'b1000
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [ism_pkg::PC_W-1:0]        prog_len;
  logic [ism_pkg::PC_W-1:0]        eff_len;
  logic [ism_pkg::PC_W-1:0]        pc;
  logic [ism_pkg::PC_W-1:0]        pc_next;
  logic [ism_pkg::CNT_W-1:0]       cnt;
  logic [ism_pkg::CNT_W-1:0]       cnt_next;
  logic                            halted;
  ism_pkg::op_t                    op;
  logic [ism_pkg::DATA_W-1:0]      imm;
  logic [ism_pkg::DATA_W-1:0]      stack_mem [ism_pkg::STACK_DEPTH];
  logic [ism_pkg::DATA_W-1:0]      top_q;
  logic [ism_pkg::DATA_W-1:0]      sec_q;
  logic [ism_pkg::CNT_W-1:0]       cnt_m1;
  logic [ism_pkg::CNT_W-1:0]       cnt_m2;
  logic [ism_pkg::SP_W-1:0]        top_idx;
  logic [ism_pkg::SP_W-1:0]        sec_idx;
  logic                            mem_we;
  logic [ism_pkg::SP_W-1:0]        mem_waddr;
  logic [ism_pkg::DATA_W-1:0]      mem_wdata;
  logic [ism_pkg::PC_W-1:0]        target;
  logic [ism_pkg::PC_W-1:0]        pc_inc;
  logic [ism_pkg::DATA_W-1:0]      product;
  ism_pkg::status_t                status;
  logic [ism_pkg::DATA_W-1:0]      rv;
  logic                            res_load;
  logic                            out_free;
  logic                            div_start;
  logic                            div_done;
  logic [ism_pkg::DATA_W-1:0]      quotient;

  // effective program length, capped at the program size
  assign eff_len = (prog_len > ism_pkg::PC_W'(ism_pkg::PROGRAM_SIZE)) ?
                   ism_pkg::PC_W'(ism_pkg::PROGRAM_SIZE) : prog_len;

  // stack indexes for the top two entries
  assign cnt_m1  = cnt - ism_pkg::CNT_W'(1);
  assign cnt_m2  = cnt - ism_pkg::CNT_W'(2);
  assign top_idx = cnt_m1[ism_pkg::SP_W-1:0];
  assign sec_idx = cnt_m2[ism_pkg::SP_W-1:0];
  assign pc_inc  = pc + 1'b1;

  // branch target: negative or out of range lands on the length
  assign target = (imm[ism_pkg::DATA_W-1] ||
                   imm >= {{(ism_pkg::DATA_W-ism_pkg::PC_W){1'b0}}, eff_len}) ?
                  eff_len : imm[ism_pkg::PC_W-1:0];

  // low word of the product only
  assign product  = sec_q * top_q;
  assign out_free = !res_valid || res_ready;
  assign item_pop = (state == S_IDLE) && item_valid;

  // operand stack memory with registered reads of the top two entries
  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_waddr] <= mem_wdata;
    top_q <= stack_mem[top_idx];
    sec_q <= stack_mem[sec_idx];
  end

  // instruction execution and next-state logic
  always_comb begin
    state_next = state;
    pc_next    = pc;
    cnt_next   = cnt;
    status     = ism_pkg::ST_RUNNING;
    rv         = '0;
    mem_we     = 1'b0;
    mem_waddr  = sec_idx;
    mem_wdata  = quotient;
    res_load   = 1'b0;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        pc_next = pc_inc;
        if (halted) begin
          status = ism_pkg::ST_HALTED;
        end else if (pc >= eff_len) begin
          status = ism_pkg::ST_ENDED;
        end else begin
          case (op)
            ism_pkg::OP_PUSH: begin
              if (cnt >= ism_pkg::CNT_W'(ism_pkg::STACK_DEPTH)) begin
                status = ism_pkg::ST_OVERFLOW;
              end else begin
                mem_waddr = cnt[ism_pkg::SP_W-1:0];
                mem_wdata = imm;
                cnt_next  = cnt + 1'b1;
              end
            end
            ism_pkg::OP_ADD, ism_pkg::OP_SUB, ism_pkg::OP_MUL, ism_pkg::OP_DIV: begin
              if (cnt < ism_pkg::CNT_W'(2)) begin
                status = ism_pkg::ST_UNDERFLOW;
              end else if (op == ism_pkg::OP_DIV) begin
                if (top_q == '0) begin
                  status   = ism_pkg::ST_DIVZERO;
                  cnt_next = cnt_m2;
                end else begin
                  div_start = 1'b1;
                end
              end else begin
                cnt_next = cnt_m1;
                case (op)
                  ism_pkg::OP_ADD: mem_wdata = sec_q + top_q;
                  ism_pkg::OP_SUB: mem_wdata = sec_q - top_q;
                  default:         mem_wdata = product;
                endcase
              end
            end
            ism_pkg::OP_RET: begin
              if (cnt == '0) begin
                status = ism_pkg::ST_UNDERFLOW;
              end else begin
                status   = ism_pkg::ST_RETURNED;
                rv       = top_q;
                cnt_next = cnt_m1;
              end
            end
            ism_pkg::OP_BZ: begin
              if (cnt == '0) begin
                status = ism_pkg::ST_UNDERFLOW;
              end else begin
                cnt_next = cnt_m1;
                if (top_q == '0) pc_next = target;
              end
            end
            ism_pkg::OP_JMP: pc_next = target;
            default: ;
          endcase
        end
        // halting steps keep the pc, clamped to the length when ended
        if (status == ism_pkg::ST_ENDED) begin
          pc_next = (pc > eff_len) ? eff_len : pc;
        end else if (status != ism_pkg::ST_RUNNING) begin
          pc_next = pc;
        end
        if (div_start) begin
          cnt_next   = cnt;
          pc_next    = pc;
          state_next = S_DIV;
        end else if (out_free) begin
          res_load   = 1'b1;
          mem_we     = (cnt_next != cnt) && (status == ism_pkg::ST_RUNNING) &&
                       (op == ism_pkg::OP_PUSH || op == ism_pkg::OP_ADD ||
                        op == ism_pkg::OP_SUB || op == ism_pkg::OP_MUL);
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt;
          pc_next  = pc;
        end
      end
      S_DIV: begin
        if (div_done) state_next = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          res_load   = 1'b1;
          mem_we     = 1'b1;
          cnt_next   = cnt_m1;
          pc_next    = pc_inc;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // quotient unit
  ism_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sec_q),
    .divisor  (top_q),
    .done     (div_done),
    .quotient (quotient)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prog_len  <= '0;
      pc        <= '0;
      cnt       <= '0;
      halted    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) prog_len <= cfg_wdata;
      if (res_load) begin
        pc        <= pc_next;
        cnt       <= cnt_next;
        res_valid <= 1'b1;
        if (status != ism_pkg::ST_RUNNING) halted <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // held instruction and result payload
  always_ff @(posedge clk) begin
    if (item_pop) begin
      op  <= item.op;
      imm <= item.imm;
    end
    if (res_load) begin
      res <= '{next_pc: pc_next, status: status, return_value: rv};
    end
  end

  // checks
  `ISM_ASSERT_NOW(a_cnt_range, clk, rst, 1'b1,
                  cnt <= ism_pkg::CNT_W'(ism_pkg::STACK_DEPTH), "stack count above depth")
  `ISM_ASSERT_NEXT(a_halt_sticky, clk, rst, halted, halted,
                   "halted flag cleared without reset")
  `ISM_ASSERT_NEXT(a_halt_on_error, clk, rst, res_load && status != ism_pkg::ST_RUNNING,
                   halted && res.status != ism_pkg::ST_RUNNING,
                   "non-running result did not halt")
  `ISM_ASSERT_NOW(a_div_from_exec, clk, rst, div_start,
                  state == S_EXEC && cnt >= ism_pkg::CNT_W'(2),
                  "divider started without operands")

endmodule

@@ design/integer_stack_machine_execute_unit.sv @@
// Integer stack machine execute unit: one instruction transaction in, one result out.
//
// Input channel s_*: s_tuser carries the action code, s_tdata the 32-bit immediate.
// Output channel m_*: m_tuser carries the status, m_tdata the next pc and return value.
// cfg_wen/cfg_wdata write the program length; write it only while the unit is idle.
//
// Instructions pass through a two-entry decode queue into the execute engine, so the
// input keeps accepting while a result waits on m_tready. The engine holds one
// instruction at a time: an idle state pops it from the queue and reads the top two
// stack words, then an execute state runs it and loads the result. An unsigned divide
// also passes through a divide state, which waits on the bit-serial quotient unit, and
// a writeback state before its result is loaded.
//
// Reset empties the queue and the output register and clears the stack count, pc,
// halted flag and program length. After a return, an error or program end the unit
// reports halted for every later instruction until reset. When m_tready stays low
// the result is held, the engine stalls, and the queue fills and drops s_tready.
module integer_stack_machine_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] immediate
  input  logic [7:0]  s_tuser,   // [3:0] action, [7:4] unused
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [8:0] next_pc, [40:9] return_value, [47:41] zero
  output logic [7:0]  m_tuser,   // [2:0] status, [7:3] zero
  input  logic        cfg_wen,
  input  logic [8:0]  cfg_wdata  // program_length
);

  logic              item_valid;
  logic              item_pop;
  ism_pkg::item_t    item;
  ism_pkg::result_t  res;

  // decode and queue
  ism_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_action  (s_tuser[ism_pkg::ACT_W-1:0]),
    .in_imm     (s_tdata),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  // execute
  ism_exec u_exec (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_valid  (m_tvalid),
    .res        (res),
    .res_ready  (m_tready)
  );

  // pack the result transaction
  assign m_tdata = {7'd0, res.return_value, res.next_pc};
  assign m_tuser = {5'd0, res.status};

endmodule
